// ----- hw/rtl/euler_rotation_matrix_defines.svh -----
// Assertion macros for the Euler rotation matrix block.
// Used by the port checker; depends on nothing.
`ifndef EULER_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ROTATION_MATRIX_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define ERM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// assert that an antecedent implies a consequent in the next cycle
`define ERM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`endif

// ----- hw/rtl/erm_pkg.sv -----
// Package for the Euler rotation matrix block: widths, CORDIC constants.
// Depends on nothing.
`timescale 1ns / 1ps
package erm_pkg;
   localparam int ANGLE_BITS_DEF     = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int FIELD_BITS = 16;
   localparam int WORK_BITS  = 34;   // Q30 values with headroom
   localparam int TABLE_LEN  = 24;
   localparam logic signed [WORK_BITS-1:0] GAIN_Q30 = 34'sd652032874;

   typedef logic signed [WORK_BITS-1:0] work_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] angle_x;
      logic [FIELD_BITS-1:0] angle_y;
      logic [FIELD_BITS-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] row0_col0;
      logic [FIELD_BITS-1:0] row0_col1;
      logic [FIELD_BITS-1:0] row0_col2;
      logic [FIELD_BITS-1:0] row1_col0;
      logic [FIELD_BITS-1:0] row1_col1;
      logic [FIELD_BITS-1:0] row1_col2;
      logic [FIELD_BITS-1:0] row2_col0;
      logic [FIELD_BITS-1:0] row2_col1;
      logic [FIELD_BITS-1:0] row2_col2;
   } rsp_type;

   // arctangent table, 2^32 per full turn
   function automatic work_type atan_entry(input logic [4:0] idx);
      work_type r;
      begin
         case (idx)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction
endpackage

// ----- hw/rtl/erm_if.sv -----
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface erm_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/erm_cordic_lane.sv -----
// One iterative CORDIC lane: cosine and sine of a binary angle in Q30.
// Depends on erm_pkg.
`timescale 1ns / 1ps
module erm_cordic_lane #(
   parameter int ANGLE_BITS   = erm_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = erm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic [ANGLE_BITS-1:0] angle,
   input  logic [4:0]            step,
   input  logic                  last,
   output erm_pkg::work_type     cos_out,
   output erm_pkg::work_type     sin_out
);
   localparam int STEPS = (CORDIC_STEPS < erm_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : erm_pkg::TABLE_LEN;
   erm_pkg::work_type x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic flip_ff, flip_in;
   logic [31:0] phase, phase2;

   // quadrant fold on load, one micro-rotation per cycle after
   always_comb begin
      phase   = 32'({angle, {(32-ANGLE_BITS){1'b0}}});
      flip_in = flip_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      phase2 = phase + 32'h8000_0000;
      if (load) begin
         flip_in = phase[31] ^ phase[30];
         x_in = erm_pkg::GAIN_Q30;
         y_in = '0;
         z_in = flip_in ? erm_pkg::work_type'(signed'(phase2))
                        : erm_pkg::work_type'(signed'(phase));
      end else if ({27'd0, step} < STEPS) begin
         if (!z_ff[erm_pkg::WORK_BITS-1]) begin
            x_in = x_ff - (y_ff >>> step);
            y_in = y_ff + (x_ff >>> step);
            z_in = z_ff - erm_pkg::atan_entry(step);
         end else begin
            x_in = x_ff + (y_ff >>> step);
            y_in = y_ff - (x_ff >>> step);
            z_in = z_ff + erm_pkg::atan_entry(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      if (last) begin
         cos_out <= flip_ff ? -x_ff : x_ff;
         sin_out <= flip_ff ? -y_ff : y_ff;
      end
   end
endmodule

// ----- hw/rtl/erm_merge.sv -----
// Merging pipeline: products of the lane results and Q1.F rounding.
// Depends on erm_pkg, erm_if.
`timescale 1ns / 1ps
module erm_merge #(
   parameter int COEF_FRAC_BITS = erm_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  erm_pkg::work_type cx, sx, cy, sy, cz, sz,
   output logic              busy,
   erm_if.source             rsp
);
   localparam int SH = 30 - COEF_FRAC_BITS;
   typedef logic signed [2*erm_pkg::WORK_BITS-1:0] wide_type;

   function automatic erm_pkg::work_type qmul(input erm_pkg::work_type a,
                                              input erm_pkg::work_type b);
      wide_type p;
      begin
         p = wide_type'(a) * wide_type'(b);
         return erm_pkg::work_type'(p >>> 30);
      end
   endfunction

   function automatic logic [erm_pkg::FIELD_BITS-1:0] to_coef(input erm_pkg::work_type v);
      erm_pkg::work_type r, one;
      begin
         one = erm_pkg::work_type'(1) <<< COEF_FRAC_BITS;
         r = (v + (erm_pkg::work_type'(1) <<< (SH-1))) >>> SH;
         if (r > one) r = one;
         if (r < -one) r = -one;
         return r[erm_pkg::FIELD_BITS-1:0];
      end
   endfunction

   // stage 1 products, stage 2 second products and sums
   erm_pkg::work_type p_cycz_ff, p_cysz_ff, p_cxsz_ff, p_czsx_ff, p_cxcz_ff;
   erm_pkg::work_type p_sxsy_ff, p_cysx_ff, p_sxsz_ff, p_cxsy_ff, p_cxcy_ff;
   erm_pkg::work_type sy1_ff, sy2_ff, sz1_ff;
   erm_pkg::work_type e_ff [9];
   logic s1_ff, s2_ff, out_valid_ff;
   erm_pkg::rsp_type out_ff;

   always_ff @(posedge clock) begin
      p_cycz_ff <= qmul(cy, cz);  p_cysz_ff <= qmul(cy, sz);
      p_cxsz_ff <= qmul(cx, sz);  p_czsx_ff <= qmul(cz, sx);
      p_cxcz_ff <= qmul(cx, cz);  p_sxsy_ff <= qmul(sx, sy);
      p_cysx_ff <= qmul(cy, sx);  p_sxsz_ff <= qmul(sx, sz);
      p_cxsy_ff <= qmul(cx, sy);  p_cxcy_ff <= qmul(cx, cy);
      sy1_ff <= sy;  sz1_ff <= sz;
      sy2_ff <= sy1_ff;
      e_ff[0] <= p_cycz_ff;
      e_ff[1] <= -p_cysz_ff;
      e_ff[2] <= sy1_ff;
      e_ff[3] <= p_cxsz_ff + qmul(p_czsx_ff, sy1_ff);
      e_ff[4] <= p_cxcz_ff - qmul(p_sxsy_ff, sz1_ff);
      e_ff[5] <= -p_cysx_ff;
      e_ff[6] <= p_sxsz_ff - qmul(p_cxcz_ff, sy1_ff);
      e_ff[7] <= qmul(p_cxsy_ff, sz1_ff) + p_czsx_ff;
      e_ff[8] <= p_cxcy_ff;
      if (s2_ff) begin
         out_ff <= '{to_coef(e_ff[0]), to_coef(e_ff[1]), to_coef(e_ff[2]),
                     to_coef(e_ff[3]), to_coef(e_ff[4]), to_coef(e_ff[5]),
                     to_coef(e_ff[6]), to_coef(e_ff[7]), to_coef(e_ff[8])};
      end
      if (reset) begin
         s1_ff <= 1'b0;  s2_ff <= 1'b0;  out_valid_ff <= 1'b0;
      end else begin
         s1_ff <= start;
         s2_ff <= s1_ff;
         if (s2_ff) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
   end

   // output register must be free before a new item may enter
   assign busy      = s1_ff | s2_ff | (out_valid_ff & ~rsp.ready);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule

// ----- hw/rtl/euler_rotation_matrix.sv -----
// Top level of the Euler XYZ rotation matrix block.
// Depends on erm_pkg, erm_if, erm_cordic_lane, erm_merge.
//
// Usage:
//  req_ channel carries angle_x/y/z (binary angles, 2^(N-1) = pi).
//  rsp_ channel returns the nine Q1.F entries of the 3x3 matrix.
//  Three CORDIC lanes, one per angle, iterate in parallel, one
//  micro-rotation per cycle; a merge pipeline forms the products.
//  After acceptance the lanes iterate, the hand-off register starts the
//  merge, whose product, sum and output registers lead to rsp_valid.
//  The next transaction is accepted only once the shared step counter of
//  the lanes has finished and the result has been handed to the merge stage.
//  A new transaction is accepted while a result waits in the output
//  register; if the receiver stalls, the lanes hold their finished
//  result and req_ready falls until the output register drains.
//  Reset (synchronous, active high) empties the lanes and the output;
//  no result is pending afterwards.
`timescale 1ns / 1ps
module euler_rotation_matrix #(
   parameter int ANGLE_BITS     = erm_pkg::ANGLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = erm_pkg::COEF_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS   = erm_pkg::CORDIC_STEPS_DEF
) (
   input logic   clock,
   input logic   reset,
   erm_if.sink   req,
   erm_if.source rsp
);
   localparam int STEPS = (CORDIC_STEPS < erm_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                              : erm_pkg::TABLE_LEN;
   logic       run_ff, done_ff, hold_ff, merge_busy, last, load;
   logic [4:0] step_ff;
   erm_pkg::work_type cx, sx, cy, sy, cz, sz;

   assign load      = req.valid & req.ready;
   assign last      = run_ff & (step_ff == 5'(STEPS));
   assign req.ready = ~run_ff & ~hold_ff;

   // step sequencer shared by the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; step_ff <= '0; done_ff <= 1'b0; hold_ff <= 1'b0;
      end else begin
         done_ff <= hold_ff & ~merge_busy;
         if (load) begin
            run_ff <= 1'b1; step_ff <= '0;
         end else if (last) begin
            run_ff <= 1'b0; hold_ff <= 1'b1;
         end else if (run_ff) begin
            step_ff <= step_ff + 5'd1;
         end
         if (hold_ff && !merge_busy) begin
            hold_ff <= 1'b0;
         end
      end
   end

   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_x (
      .clock, .load, .angle(req.data.angle_x[ANGLE_BITS-1:0]), .step(step_ff),
      .last, .cos_out(cx), .sin_out(sx));
   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_y (
      .clock, .load, .angle(req.data.angle_y[ANGLE_BITS-1:0]), .step(step_ff),
      .last, .cos_out(cy), .sin_out(sy));
   erm_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_z (
      .clock, .load, .angle(req.data.angle_z[ANGLE_BITS-1:0]), .step(step_ff),
      .last, .cos_out(cz), .sin_out(sz));

   erm_merge #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_merge (
      .clock, .reset, .start(done_ff), .cx, .sx, .cy, .sy, .cz, .sz,
      .busy(merge_busy), .rsp);
endmodule

// ----- hw/rtl/erm_checker.sv -----
// Port checker for the Euler rotation matrix block, bound to the top.
// Depends on erm_pkg, euler_rotation_matrix_defines.svh.
`timescale 1ns / 1ps
`include "euler_rotation_matrix_defines.svh"
module erm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input erm_pkg::rsp_type rsp_data
);
   // pending result holds while stalled
   `ERM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ERM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   // an accepted transaction blocks the input for the next cycle
   `ERM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind euler_rotation_matrix erm_checker u_erm_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

// ----- dv/testbench.sv -----
// Self-checking testbench for the Euler XYZ rotation matrix block.
// Depends on erm_pkg, erm_if and euler_rotation_matrix; predicts each matrix bit for bit.
`timescale 1ns / 1ps
module testbench;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam int  DRAIN_CYCLES   = 40;
   localparam int  RANDOM_ITEMS   = 1500;
   localparam longint FULL_TURN   = 64'sd4294967296;

   logic clock;
   logic reset;

   erm_if #(.payload_type(erm_pkg::req_type)) req_bus ();
   erm_if #(.payload_type(erm_pkg::rsp_type)) rsp_bus ();

   euler_rotation_matrix dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus.sink),
      .rsp  (rsp_bus.source)
   );

   erm_pkg::req_type angle_queue[$];
   erm_pkg::rsp_type matrix_queue[$];
   bit      stimulus_done;
   int      mismatch_count;
   int      idle_cycles;

   // floor shift of a signed value
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   // CORDIC cosine and sine of one binary angle, Q30
   function automatic void cordic_cos_sin(input logic [15:0] raw, output longint c,
                                          output longint s);
      logic [31:0] phase;
      bit          flip;
      longint      x, y, z, nx;
      begin
         phase = {raw, 16'h0000};
         flip  = phase[31] ^ phase[30];
         if (flip) phase = phase + 32'h8000_0000;
         z = phase[31] ? longint'(phase) - FULL_TURN : longint'(phase);
         x = longint'(erm_pkg::GAIN_Q30);
         y = 0;
         for (int i = 0; i < erm_pkg::CORDIC_STEPS_DEF && i < erm_pkg::TABLE_LEN; i++) begin
            if (z >= 0) begin
               nx = x - floor_shift(y, i);
               y  = y + floor_shift(x, i);
               z  = z - longint'(erm_pkg::atan_entry(i[4:0]));
            end else begin
               nx = x + floor_shift(y, i);
               y  = y - floor_shift(x, i);
               z  = z + longint'(erm_pkg::atan_entry(i[4:0]));
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c = x;
         s = y;
      end
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return floor_shift(a * b, 30);
   endfunction

   // round half up to Q1.14 and saturate to +-1.0
   function automatic logic [15:0] to_q14(input longint v);
      longint r;
      longint one;
      one = 64'sd1 <<< erm_pkg::COEF_FRAC_BITS_DEF;
      r = floor_shift(v + (64'sd1 <<< (29 - erm_pkg::COEF_FRAC_BITS_DEF)),
                      30 - erm_pkg::COEF_FRAC_BITS_DEF);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[15:0];
   endfunction

   function automatic erm_pkg::rsp_type rotation_matrix(input erm_pkg::req_type a);
      longint cx, sx, cy, sy, cz, sz;
      erm_pkg::rsp_type m;
      cordic_cos_sin(a.angle_x, cx, sx);
      cordic_cos_sin(a.angle_y, cy, sy);
      cordic_cos_sin(a.angle_z, cz, sz);
      m.row0_col0 = to_q14(q30_mul(cy, cz));
      m.row0_col1 = to_q14(-q30_mul(cy, sz));
      m.row0_col2 = to_q14(sy);
      m.row1_col0 = to_q14(q30_mul(cx, sz) + q30_mul(q30_mul(cz, sx), sy));
      m.row1_col1 = to_q14(q30_mul(cx, cz) - q30_mul(q30_mul(sx, sy), sz));
      m.row1_col2 = to_q14(-q30_mul(cy, sx));
      m.row2_col0 = to_q14(q30_mul(sx, sz) - q30_mul(q30_mul(cx, cz), sy));
      m.row2_col1 = to_q14(q30_mul(q30_mul(cx, sy), sz) + q30_mul(cz, sx));
      m.row2_col2 = to_q14(q30_mul(cx, cy));
      return m;
   endfunction

   function automatic logic [15:0] random_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return {2'($urandom_range(0, 3)), 14'h0000};
         3: return {2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stimulus
   initial begin
      logic [15:0] corners[8];
      erm_pkg::req_type t;
      corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                  16'h7FFF, 16'h8001, 16'h3FFF, 16'hFFFF};
      reset = 1'b1;
      stimulus_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // extremes, quarter turns and exactly -pi on each axis
      for (int i = 0; i < 8; i++) begin
         t.angle_x = corners[i];
         t.angle_y = corners[(i + 3) % 8];
         t.angle_z = corners[(i + 5) % 8];
         angle_queue.push_back(t);
      end
      for (int i = 0; i < 8; i++) begin
         t.angle_x = corners[i];
         t.angle_y = corners[i];
         t.angle_z = corners[i];
         angle_queue.push_back(t);
      end
      t = '{16'h8000, 16'h0000, 16'h0000}; angle_queue.push_back(t);
      t = '{16'h0000, 16'h8000, 16'h0000}; angle_queue.push_back(t);
      t = '{16'h0000, 16'h0000, 16'h8000}; angle_queue.push_back(t);
      t = '{16'h0000, 16'h4000, 16'h0000}; angle_queue.push_back(t);
      t = '{16'h0000, 16'hC000, 16'h0000}; angle_queue.push_back(t);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         t.angle_x = random_angle();
         t.angle_y = random_angle();
         t.angle_z = random_angle();
         angle_queue.push_back(t);
      end
      stimulus_done = 1'b1;
   end

   // driver: random waits between transactions, with back-to-back stretches; each predicted on acceptance
   int req_wait;
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data  <= '0;
         req_wait      <= $urandom_range(0, 13);
      end else if (req_bus.valid && req_bus.ready) begin
         matrix_queue.push_back(rotation_matrix(req_bus.data));
         gap = $urandom_range(0, 13);
         if (gap == 0 && angle_queue.size() > 0) begin
            // back-to-back stretch
            req_bus.data <= angle_queue.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
            req_wait      <= gap;
         end
      end else if (!req_bus.valid) begin
         if (req_wait > 0) req_wait <= req_wait - 1;
         else if (angle_queue.size() > 0) begin
            req_bus.valid <= 1'b1;
            req_bus.data  <= angle_queue.pop_front();
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   int rsp_wait;
   always @(posedge clock) begin
      erm_pkg::rsp_type want;
      erm_pkg::rsp_type got;
      int gap;
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         rsp_wait       <= $urandom_range(0, 13);
         mismatch_count <= 0;
         idle_cycles    <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (matrix_queue.size() == 0) begin
               if (mismatch_count < 10) $display("unexpected result %h", got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = matrix_queue.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10)
                     $display("matrix mismatch: expected %h actual %h", want, got);
                  mismatch_count <= mismatch_count + 1;
               end
            end
            gap = $urandom_range(0, 13);
            if (gap != 0) begin
               rsp_bus.ready <= 1'b0;
               rsp_wait      <= gap - 1;
            end
         end else if (!rsp_bus.ready) begin
            if (rsp_wait > 0) rsp_wait <= rsp_wait - 1;
            else rsp_bus.ready <= 1'b1;
         end
      end
   end

   // end of run and watchdog
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
         if (stimulus_done && angle_queue.size() == 0 && !req_bus.valid
             && matrix_queue.size() == 0) begin
            repeat (DRAIN_CYCLES) @(posedge clock);
            if (mismatch_count == 0 && matrix_queue.size() == 0)
               $display("testbench passed");
            else
               $display("testbench failed");
            $finish;
         end
      end
   end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/erm_pkg.sv
hw/rtl/erm_if.sv
hw/rtl/erm_cordic_lane.sv
hw/rtl/erm_merge.sv
hw/rtl/euler_rotation_matrix.sv
hw/rtl/erm_checker.sv
dv/testbench.sv
